[hw/rtl/b64e_pkg.sv]
// ----------------------------------------------------------------------------
// b64e_pkg
// Types and the sextet-to-character map for the base64url stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned CharWidth   = 7;
  localparam int unsigned SextetWidth = 6;

  // Position of the next byte within its 3-byte group
  typedef enum logic [1:0] {
    PhaseFirst  = 2'd0,
    PhaseSecond = 2'd1,
    PhaseThird  = 2'd2
  } phase_t;

  // One queued output character and its end-of-message mark.
  typedef struct packed {
    logic [CharWidth-1:0] code_char;
    logic                 last_char;
  } char_entry_t;

  // URL-safe alphabet: A-Z, a-z, 0-9, '-', '_'
  function automatic logic [CharWidth-1:0] sextet_to_char(
    input logic [SextetWidth-1:0] v
  );
    logic [CharWidth-1:0] c;
    if (v < 6'd26) begin
      c = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'd71 + {1'b0, v};          // 'a' - 26
    end else if (v < 6'd62) begin
      c = {1'b0, v} - 7'd4;           // '0' - 52
    end else if (v == 6'd62) begin
      c = 7'd45;                      // '-'
    end else begin
      c = 7'd95;                      // '_'
    end
    return c;
  endfunction

endpackage

[hw/rtl/base64url_stream_encoder_core.sv]
// ----------------------------------------------------------------------------
// base64url_stream_encoder_core
// Encodes a byte stream into unpadded URL-safe base64 characters.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry data_byte and end_of_message.
// Output channel: out_valid/out_ready carry code_char and last_char, one
// character per request.
// Each byte yields one or two characters; a byte flagged end_of_message
// flushes the leftover bits as a final zero-filled character (unless the
// group is complete) and the next byte starts a new group.
// Order: a byte's characters are written into the character queue on
// acceptance and offered from its head after any characters queued earlier.
// Throughput: a byte can be taken every cycle while the 4-entry character
// queue has room for two; the output side moves one character per cycle
// while out_ready is high, so a stream settles to 4 characters per 3 bytes,
// 2 characters per byte worst case (every byte ends a message).
// Stalls: when out_ready is low, characters accumulate in the queue and
// in_ready drops once fewer than two slots are free; nothing is lost.
// Reset (rst, synchronous): queue emptied, group phase and carry cleared.
// ----------------------------------------------------------------------------
module base64url_stream_encoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] code_char,
  output logic       last_char
);

  localparam int unsigned Depth = 4;

  b64e_pkg::phase_t group_phase, group_phase_next;
  logic [3:0] carry_bits, carry_bits_next;

  b64e_pkg::char_entry_t queue [Depth];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  logic       push;
  logic       pop;
  logic       push_two;
  logic [5:0] sextet0;
  logic [5:0] sextet1;
  logic       last1;
  b64e_pkg::char_entry_t entry0;
  b64e_pkg::char_entry_t entry1;
  b64e_pkg::char_entry_t head;

  assign in_ready  = (count <= 3'd2);
  assign push      = in_valid && in_ready;
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;

  always_comb begin
    group_phase_next = group_phase;
    carry_bits_next  = carry_bits;
    sextet0          = data_byte[7:2];
    sextet1          = {data_byte[1:0], 4'b0000};
    last1            = 1'b1;
    push_two         = end_of_message;
    case (group_phase)
      b64e_pkg::PhaseSecond: begin
        sextet0          = {carry_bits[1:0], data_byte[7:4]};
        sextet1          = {data_byte[3:0], 2'b00};
        carry_bits_next  = data_byte[3:0];
        group_phase_next = b64e_pkg::PhaseThird;
      end
      b64e_pkg::PhaseThird: begin
        sextet0          = {carry_bits, data_byte[7:6]};
        sextet1          = data_byte[5:0];
        last1            = end_of_message;
        push_two         = 1'b1;
        carry_bits_next  = 4'd0;
        group_phase_next = b64e_pkg::PhaseFirst;
      end
      default: begin
        // phase 3 never arises; handled like start of group
        carry_bits_next  = {2'b00, data_byte[1:0]};
        group_phase_next = b64e_pkg::PhaseSecond;
      end
    endcase
    if (end_of_message) begin
      carry_bits_next  = 4'd0;
      group_phase_next = b64e_pkg::PhaseFirst;
    end
    entry0.code_char = b64e_pkg::sextet_to_char(sextet0);
    entry0.last_char = 1'b0;
    entry1.code_char = b64e_pkg::sextet_to_char(sextet1);
    entry1.last_char = last1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase <= b64e_pkg::PhaseFirst;
      carry_bits  <= 4'd0;
      wr_ptr      <= 2'd0;
      rd_ptr      <= 2'd0;
      count       <= 3'd0;
    end else begin
      if (push) begin
        group_phase <= group_phase_next;
        carry_bits  <= carry_bits_next;
        wr_ptr      <= wr_ptr + (push_two ? 2'd2 : 2'd1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (push ? (push_two ? 3'd2 : 3'd1) : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry0;
      if (push_two) begin
        queue[wr_ptr + 2'd1] <= entry1;
      end
    end
  end

  assign head      = queue[rd_ptr];
  assign code_char = head.code_char;
  assign last_char = head.last_char;

endmodule
